[hdl/psrf_pkg.sv]
// Package: shared constants, codes and types of the packet source rate filter
`timescale 1ns / 1ps
package psrf_pkg;
    localparam int ALLOW_DEPTH_DEF = 16;
    localparam int BLOCK_DEPTH_DEF = 64;
    localparam int TRACK_DEPTH_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 31;

    localparam logic [31:0] PACKET_LIMIT_RST = 32'd500;
    localparam logic [31:0] SYN_LIMIT_RST    = 32'd200;
    localparam logic [63:0] WINDOW_RST       = 64'd1000000000;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [15:0] ETH_HDR_MIN = 16'd14;
    localparam logic [15:0] IP_HDR_MIN  = 16'd34;
    localparam logic [3:0]  IHL_MIN     = 4'd5;
    localparam logic [16:0] TCP_FIXED   = 17'd34;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_PACKET      = 2'd0,
        OP_WRITE_ALLOW = 2'd1,
        OP_WRITE_BLOCK = 2'd2,
        OP_UNUSED      = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACKET_LIMIT = 2'd0,
        CFG_SYN_LIMIT    = 2'd1,
        CFG_WINDOW       = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RSN_OK        = 3'd0,
        RSN_ALLOW     = 3'd1,
        RSN_BLOCK     = 3'd2,
        RSN_RATE      = 3'd3,
        RSN_SYN       = 3'd4,
        RSN_MALFORMED = 3'd5,
        RSN_NOT_IPV4  = 3'd6,
        RSN_WRITE     = 3'd7
    } t_reason;

    typedef struct packed {
        logic        wr;
        logic [31:0] key;
        logic        mark;
    } t_list_cmd;

    typedef struct packed {
        logic               en;
        logic               wr_start;
        logic [31:0]        key;
        logic [COUNT_W-1:0] count;
        logic [63:0]        start;
    } t_trk_upd;
endpackage

[hdl/psrf_if.sv]
// Interfaces: item, result and configuration channels
`timescale 1ns / 1ps
interface psrf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] source_address;
    logic [7:0]  ip_protocol;
    logic [3:0]  header_words;
    logic        syn_flag;
    logic        ack_flag;
    logic [63:0] arrival_time;
    logic        entry_mark;
    modport source (output valid, operation, frame_length, ether_type, source_address,
                    ip_protocol, header_words, syn_flag, ack_flag, arrival_time,
                    entry_mark, input ready);
    modport sink (input valid, operation, frame_length, ether_type, source_address,
                  ip_protocol, header_words, syn_flag, ack_flag, arrival_time,
                  entry_mark, output ready);
endinterface

interface psrf_out_if;
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [2:0] reason;
    logic       table_full;
    modport source (output valid, verdict, reason, table_full, input ready);
    modport sink (input valid, verdict, reason, table_full, output ready);
endinterface

interface psrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/psrf_list_cell.sv]
// List cell: one allowlist or blocklist entry with key match and free chain
`timescale 1ns / 1ps
module psrf_list_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psrf_pkg::t_list_cmd  i_cmd,
    input  logic                 i_any_hit,
    input  logic                 i_free_in,
    output logic                 o_free_out,
    output logic                 o_hit,
    output logic                 o_active
);
    logic        r_valid;
    logic [31:0] r_key;
    logic        r_mark;
    logic        w_sel;

    assign o_hit      = r_valid && (r_key == i_cmd.key);
    assign o_active   = o_hit && r_mark;
    assign o_free_out = i_free_in || !r_valid;
    assign w_sel      = i_cmd.wr && (o_hit || (!i_any_hit && !r_valid && !i_free_in));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
            r_mark  <= i_cmd.mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_key <= i_cmd.key;
        end
    end
endmodule

[hdl/psrf_list.sv]
// List table: row of list cells with lowest-free insert
`timescale 1ns / 1ps
module psrf_list #(
    parameter int DEPTH = psrf_pkg::BLOCK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psrf_pkg::t_list_cmd i_cmd,
    output logic                o_active,
    output logic                o_full
);
    logic [DEPTH:0]   w_free;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_active;
    logic             w_any_hit;

    assign w_free[0] = 1'b0;
    assign w_any_hit = |w_hit;
    assign o_active  = |w_active;
    assign o_full    = !w_any_hit && !w_free[DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        psrf_list_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_any_hit  (w_any_hit),
            .i_free_in  (w_free[g]),
            .o_free_out (w_free[g+1]),
            .o_hit      (w_hit[g]),
            .o_active   (w_active[g])
        );
    end
endmodule

[hdl/psrf_track_cell.sv]
// Tracking cell: one source window entry with its recency rank
`timescale 1ns / 1ps
module psrf_track_cell #(
    parameter int RW  = 6,
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [31:0]                   i_key,
    input  logic                          i_sel,
    input  psrf_pkg::t_trk_upd            i_upd,
    input  logic [RW-1:0]                 i_touch_rank,
    input  logic [RW-1:0]                 i_rank_max,
    output logic                          o_hit,
    output logic [psrf_pkg::COUNT_W-1:0]  o_count,
    output logic [63:0]                   o_start,
    output logic [RW-1:0]                 o_rank
);
    logic                         r_valid;
    logic [31:0]                  r_key;
    logic [psrf_pkg::COUNT_W-1:0] r_count;
    logic [63:0]                  r_start;
    logic [RW-1:0]                r_rank;

    assign o_hit   = r_valid && (r_key == i_key);
    assign o_count = r_count;
    assign o_start = r_start;
    assign o_rank  = r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= RW'(IDX);
        end else if (i_upd.en && i_sel) begin
            r_valid <= 1'b1;
            r_rank  <= i_rank_max;
        end else if (i_upd.en && (r_rank > i_touch_rank)) begin
            r_rank <= r_rank - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_sel) begin
            r_key   <= i_upd.key;
            r_count <= i_upd.count;
            if (i_upd.wr_start) begin
                r_start <= i_upd.start;
            end
        end
    end
endmodule

[hdl/psrf_track.sv]
// Tracking table: row of tracking cells, LRU pick and window count update
`timescale 1ns / 1ps
module psrf_track #(
    parameter int DEPTH = psrf_pkg::TRACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_key,
    input  logic [63:0] i_now,
    input  logic [63:0] i_window,
    input  logic [31:0] i_limit,
    input  logic        i_pick,
    input  logic        i_update,
    output logic        o_exceed
);
    localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [RW-1:0] RANK_MAX = RW'(DEPTH - 1);

    logic [DEPTH-1:0]             w_hit;
    logic [psrf_pkg::COUNT_W-1:0] w_count [DEPTH];
    logic [63:0]                  w_start [DEPTH];
    logic [RW-1:0]                w_rank  [DEPTH];
    logic [DEPTH-1:0]             w_victim;
    logic [DEPTH-1:0]             w_pick;
    logic [psrf_pkg::COUNT_W-1:0] w_pcount;
    logic [63:0]                  w_pstart;
    logic [RW-1:0]                w_prank;

    logic [DEPTH-1:0]             r_sel;
    logic                         r_found;
    logic [psrf_pkg::COUNT_W-1:0] r_count;
    logic [63:0]                  r_start;
    logic [RW-1:0]                r_rank;

    logic [63:0]                  w_age;
    logic                         w_new_win;
    logic [psrf_pkg::COUNT_W-1:0] w_next;
    psrf_pkg::t_trk_upd           w_upd;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_victim[k] = (w_rank[k] == '0);
        end
        w_pick   = (|w_hit) ? w_hit : w_victim;
        w_pcount = '0;
        w_pstart = '0;
        w_prank  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_pick[k]) begin
                w_pcount = w_pcount | w_count[k];
                w_pstart = w_pstart | w_start[k];
                w_prank  = w_prank | w_rank[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pick) begin
            r_sel   <= w_pick;
            r_found <= |w_hit;
            r_count <= w_pcount;
            r_start <= w_pstart;
            r_rank  <= w_prank;
        end
    end

    always_comb begin
        w_age     = i_now - r_start;
        w_new_win = !r_found || (w_age >= i_window);
        w_next    = (r_count == psrf_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;
        w_upd.en       = i_update;
        w_upd.wr_start = w_new_win;
        w_upd.key      = i_key;
        w_upd.count    = w_new_win ? psrf_pkg::COUNT_W'(1) : w_next;
        w_upd.start    = i_now;
        o_exceed       = !w_new_win && ({1'b0, w_next} > i_limit);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        psrf_track_cell #(
            .RW  (RW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key        (i_key),
            .i_sel        (r_sel[g]),
            .i_upd        (w_upd),
            .i_touch_rank (r_rank),
            .i_rank_max   (RANK_MAX),
            .o_hit        (w_hit[g]),
            .o_count      (w_count[g]),
            .o_start      (w_start[g]),
            .o_rank       (w_rank[g])
        );
    end
endmodule

[hdl/packet_source_rate_filter.sv]
// Top level: packet source rate filter with list and tracking tables
// Throughput: one item at a time; a packet steps through lookup and, as it needs them,
// two steps per tracking table and a blocklist insert, a table write through lookup only;
// the result register, until taken, gates the next item.
// Reset: synchronous active-low i_rst_n empties all lists and tracking tables, restores
// identity LRU order and the default limits and window length.
`timescale 1ns / 1ps
module packet_source_rate_filter #(
    parameter int ALLOW_DEPTH = psrf_pkg::ALLOW_DEPTH_DEF,
    parameter int BLOCK_DEPTH = psrf_pkg::BLOCK_DEPTH_DEF,
    parameter int TRACK_DEPTH = psrf_pkg::TRACK_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    psrf_in_if.sink    i_in,
    psrf_cfg_if.sink   i_cfg,
    psrf_out_if.source o_out
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_RATE_A = 7'b0000100,
        S_RATE_B = 7'b0001000,
        S_SYN_A  = 7'b0010000,
        S_SYN_B  = 7'b0100000,
        S_BLOCK  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_packet_limit, r_syn_limit;
    logic [63:0] r_window;

    logic [1:0]  r_op;
    logic [15:0] r_flen, r_etype;
    logic [31:0] r_src;
    logic [7:0]  r_proto;
    logic [3:0]  r_hwords;
    logic        r_syn, r_ack, r_mark;
    logic [63:0] r_now;

    logic        r_ovalid, r_verdict, r_full;
    logic [2:0]  r_reason, r_block_reason;
    logic        n_load, n_verdict, n_full;
    logic [2:0]  n_reason, n_block_reason;

    logic        w_accept;
    logic        w_allow_active, w_allow_full, w_block_active, w_block_full;
    logic        w_rate_exceed, w_syn_exceed;
    logic        w_tcp_bad;
    psrf_pkg::t_list_cmd w_allow_cmd, w_block_cmd;

    assign i_in.ready       = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign w_accept         = i_in.valid && i_in.ready;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovalid;
    assign o_out.verdict    = r_verdict;
    assign o_out.reason     = r_reason;
    assign o_out.table_full = r_full;

    assign w_tcp_bad = (r_hwords < psrf_pkg::IHL_MIN) ||
                       ({1'b0, r_flen} < (psrf_pkg::TCP_FIXED + {11'd0, r_hwords, 2'b00}));

    always_comb begin
        w_allow_cmd.wr   = (r_state == S_LOOK) && (r_op == psrf_pkg::OP_WRITE_ALLOW);
        w_allow_cmd.key  = r_src;
        w_allow_cmd.mark = r_mark;
        w_block_cmd.wr   = ((r_state == S_LOOK) && (r_op == psrf_pkg::OP_WRITE_BLOCK)) ||
                           (r_state == S_BLOCK);
        w_block_cmd.key  = r_src;
        w_block_cmd.mark = (r_state == S_BLOCK) ? 1'b1 : r_mark;
    end

    always_comb begin
        n_state        = r_state;
        n_load         = 1'b0;
        n_verdict      = 1'b0;
        n_reason       = psrf_pkg::RSN_OK;
        n_full         = 1'b0;
        n_block_reason = r_block_reason;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_load  = 1'b1;
                n_state = S_IDLE;
                if (r_op == psrf_pkg::OP_WRITE_ALLOW) begin
                    n_reason = psrf_pkg::RSN_WRITE;
                    n_full   = w_allow_full;
                end else if (r_op == psrf_pkg::OP_WRITE_BLOCK) begin
                    n_reason = psrf_pkg::RSN_WRITE;
                    n_full   = w_block_full;
                end else if (r_op == psrf_pkg::OP_UNUSED) begin
                    n_reason = psrf_pkg::RSN_WRITE;
                end else if (r_flen < psrf_pkg::ETH_HDR_MIN) begin
                    n_verdict = 1'b1;
                    n_reason  = psrf_pkg::RSN_MALFORMED;
                end else if (r_etype != psrf_pkg::ETH_IPV4) begin
                    n_reason = psrf_pkg::RSN_NOT_IPV4;
                end else if (r_flen < psrf_pkg::IP_HDR_MIN) begin
                    n_verdict = 1'b1;
                    n_reason  = psrf_pkg::RSN_MALFORMED;
                end else if (w_allow_active) begin
                    n_reason = psrf_pkg::RSN_ALLOW;
                end else if (w_block_active) begin
                    n_verdict = 1'b1;
                    n_reason  = psrf_pkg::RSN_BLOCK;
                end else begin
                    n_load  = 1'b0;
                    n_state = S_RATE_A;
                end
            end
            S_RATE_A: begin
                n_state = S_RATE_B;
            end
            S_RATE_B: begin
                if (w_rate_exceed) begin
                    n_block_reason = psrf_pkg::RSN_RATE;
                    n_state        = S_BLOCK;
                end else if (r_proto == psrf_pkg::PROTO_TCP && w_tcp_bad) begin
                    n_load    = 1'b1;
                    n_verdict = 1'b1;
                    n_reason  = psrf_pkg::RSN_MALFORMED;
                    n_state   = S_IDLE;
                end else if (r_proto == psrf_pkg::PROTO_TCP && r_syn && !r_ack) begin
                    n_state = S_SYN_A;
                end else begin
                    n_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SYN_A: begin
                n_state = S_SYN_B;
            end
            S_SYN_B: begin
                if (w_syn_exceed) begin
                    n_block_reason = psrf_pkg::RSN_SYN;
                    n_state        = S_BLOCK;
                end else begin
                    n_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BLOCK: begin
                n_load    = 1'b1;
                n_verdict = 1'b1;
                n_reason  = r_block_reason;
                n_full    = w_block_full;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ovalid       <= 1'b0;
            r_packet_limit <= psrf_pkg::PACKET_LIMIT_RST;
            r_syn_limit    <= psrf_pkg::SYN_LIMIT_RST;
            r_window       <= psrf_pkg::WINDOW_RST;
        end else begin
            r_state <= n_state;
            if (n_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    psrf_pkg::CFG_PACKET_LIMIT: r_packet_limit <= i_cfg.data[31:0];
                    psrf_pkg::CFG_SYN_LIMIT:    r_syn_limit    <= i_cfg.data[31:0];
                    psrf_pkg::CFG_WINDOW:       r_window       <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_block_reason <= n_block_reason;
        if (n_load) begin
            r_verdict <= n_verdict;
            r_reason  <= n_reason;
            r_full    <= n_full;
        end
        if (w_accept) begin
            r_op     <= i_in.operation;
            r_flen   <= i_in.frame_length;
            r_etype  <= i_in.ether_type;
            r_src    <= i_in.source_address;
            r_proto  <= i_in.ip_protocol;
            r_hwords <= i_in.header_words;
            r_syn    <= i_in.syn_flag;
            r_ack    <= i_in.ack_flag;
            r_now    <= i_in.arrival_time;
            r_mark   <= i_in.entry_mark;
        end
    end

    psrf_list #(.DEPTH(ALLOW_DEPTH)) u_allow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_allow_cmd),
        .o_active (w_allow_active),
        .o_full   (w_allow_full)
    );

    psrf_list #(.DEPTH(BLOCK_DEPTH)) u_block (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_block_cmd),
        .o_active (w_block_active),
        .o_full   (w_block_full)
    );

    psrf_track #(.DEPTH(TRACK_DEPTH)) u_rate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_src),
        .i_now    (r_now),
        .i_window (r_window),
        .i_limit  (r_packet_limit),
        .i_pick   (r_state == S_RATE_A),
        .i_update (r_state == S_RATE_B),
        .o_exceed (w_rate_exceed)
    );

    psrf_track #(.DEPTH(TRACK_DEPTH)) u_syn (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (r_src),
        .i_now    (r_now),
        .i_window (r_window),
        .i_limit  (r_syn_limit),
        .i_pick   (r_state == S_SYN_A),
        .i_update (r_state == S_SYN_B),
        .o_exceed (w_syn_exceed)
    );
endmodule
